// ===== rtl/rcvs_pkg.sv =====
package rcvs_pkg;

  localparam int unsigned MAX_SLOTS_DEF = 16;
  localparam int unsigned QUEUE_DEPTH   = 2;

  localparam int unsigned ID_W      = 64;
  localparam int unsigned EPOCH_W   = 32;
  localparam int unsigned PURPOSE_W = 4;
  localparam int unsigned BOOT_W    = 32;
  localparam int unsigned TARGET_W  = 4;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_CTX_NETWORK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CTX_GK_EPOCH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REQ_PURPOSE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REQ_PEER     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REQ_PINNED   = 3'd4;

  typedef enum logic [1:0] {
    CLS_SAME = 2'd0,
    CLS_FREE = 2'd1,
    CLS_PIN  = 2'd2,
    CLS_LRU  = 2'd3
  } cls_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_SMALL = 2'd1,
    STATUS_PIN   = 2'd2,
    STATUS_FULL  = 2'd3
  } status_t;

  typedef struct packed {
    cls_t cls;
    logic use_slot;
    logic last;
  } tag_t;

endpackage

// ===== rtl/rcvs_queue.sv =====
module rcvs_queue #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_stall,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_stall,
  output logic [W-1:0] pop_data
);
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0] num_r, num_nxt;
  logic          push, pop;

  assign push_stall = (num_r == NW'(DEPTH));
  assign pop_valid  = (num_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && !push_stall;
  assign pop        = pop_valid && !pop_stall;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    num_nxt    = num_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      num_nxt = num_r + NW'(1);
    end else if (pop && !push) begin
      num_nxt = num_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      num_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      num_r    <= num_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/rcvs_front.sv =====
module rcvs_front #(
  parameter int unsigned MAX_SLOTS = rcvs_pkg::MAX_SLOTS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [rcvs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [rcvs_pkg::CFG_DAT_W-1:0]        cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_stored_valid,
  input  logic [rcvs_pkg::PURPOSE_W-1:0]        in_stored_purpose,
  input  logic [rcvs_pkg::ID_W-1:0]             in_stored_peer,
  input  logic [rcvs_pkg::ID_W-1:0]             in_stored_network,
  input  logic [rcvs_pkg::EPOCH_W-1:0]          in_stored_created_epoch,
  input  logic                                  in_stored_pinned,
  input  logic [rcvs_pkg::BOOT_W-1:0]           in_stored_last_boot,
  input  logic                                  in_stored_revoked,
  input  logic                                  in_last,
  output logic                                  push_valid,
  input  logic                                  push_stall,
  output rcvs_pkg::tag_t                        push_tag,
  output logic [$clog2(MAX_SLOTS)-1:0]          push_idx,
  output logic [$clog2(MAX_SLOTS+1)-1:0]        push_count,
  output logic [rcvs_pkg::BOOT_W-1:0]           push_boot,
  output logic                                  req_pinned
);
  import rcvs_pkg::*;

  localparam int unsigned IW = $clog2(MAX_SLOTS);
  localparam int unsigned CW = $clog2(MAX_SLOTS + 1);

  logic [ID_W-1:0]      ctx_network_r;
  logic [EPOCH_W-1:0]   ctx_gk_epoch_r;
  logic [PURPOSE_W-1:0] req_purpose_r;
  logic [ID_W-1:0]      req_peer_r;
  logic                 req_pinned_r;

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] count_after;
  logic          in_range;
  logic          same, live, accept;
  logic [EPOCH_W:0] epoch_lim;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_network_r  <= '0;
      ctx_gk_epoch_r <= '0;
      req_purpose_r  <= '0;
      req_peer_r     <= '0;
      req_pinned_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CTX_NETWORK:  ctx_network_r  <= cfg_wdata[ID_W-1:0];
        REG_CTX_GK_EPOCH: ctx_gk_epoch_r <= cfg_wdata[EPOCH_W-1:0];
        REG_REQ_PURPOSE:  req_purpose_r  <= cfg_wdata[PURPOSE_W-1:0];
        REG_REQ_PEER:     req_peer_r     <= cfg_wdata[ID_W-1:0];
        REG_REQ_PINNED:   req_pinned_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign req_pinned = req_pinned_r;
  assign in_stall   = push_stall;
  assign push_valid = in_valid;
  assign accept     = in_valid && !push_stall;

  assign in_range    = (cnt_r < CW'(MAX_SLOTS));
  assign count_after = in_range ? cnt_r + CW'(1) : cnt_r;

  // expiry test without wrap
  assign epoch_lim = {1'b0, in_stored_created_epoch} + (EPOCH_W+1)'(2);

  assign same = in_stored_valid && (in_stored_purpose == req_purpose_r) &&
                (in_stored_peer == req_peer_r);
  assign live = in_stored_valid && (in_stored_network == ctx_network_r) &&
                (epoch_lim > {1'b0, ctx_gk_epoch_r}) && !in_stored_revoked;

  always_comb begin
    push_tag.use_slot = in_range;
    push_tag.last     = in_last;
    if (same) begin
      push_tag.cls = CLS_SAME;
    end else if (!live) begin
      push_tag.cls = CLS_FREE;
    end else if (in_stored_pinned) begin
      push_tag.cls = CLS_PIN;
    end else begin
      push_tag.cls = CLS_LRU;
    end
  end

  assign push_idx   = cnt_r[IW-1:0];
  assign push_count = count_after;
  assign push_boot  = in_stored_last_boot;

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept) begin
      cnt_nxt = in_last ? '0 : count_after;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/rcvs_back.sv =====
module rcvs_back #(
  parameter int unsigned MAX_SLOTS = rcvs_pkg::MAX_SLOTS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  pop_valid,
  output logic                                  pop_stall,
  input  rcvs_pkg::tag_t                        pop_tag,
  input  logic [$clog2(MAX_SLOTS)-1:0]          pop_idx,
  input  logic [$clog2(MAX_SLOTS+1)-1:0]        pop_count,
  input  logic [rcvs_pkg::BOOT_W-1:0]           pop_boot,
  input  logic                                  req_pinned,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [rcvs_pkg::STATUS_W-1:0]         out_status,
  output logic [rcvs_pkg::TARGET_W-1:0]         out_target_index
);
  import rcvs_pkg::*;

  localparam int unsigned IW = $clog2(MAX_SLOTS);
  localparam int unsigned CW = $clog2(MAX_SLOTS + 1);

  logic          same_found_r, same_found_nxt;
  logic [IW-1:0] same_idx_r, same_idx_nxt;
  logic          free_found_r, free_found_nxt;
  logic [IW-1:0] free_idx_r, free_idx_nxt;
  logic          lru_found_r, lru_found_nxt;
  logic [IW-1:0] lru_idx_r, lru_idx_nxt;
  logic [BOOT_W-1:0] oldest_boot_r, oldest_boot_nxt;
  logic [CW-1:0] pin_cnt_r, pin_cnt_nxt;

  logic          out_valid_r, out_valid_nxt;
  status_t       status_r, status_nxt;
  logic [TARGET_W-1:0] target_r, target_nxt;

  logic          pop, out_free;
  logic [IW-1:0] pick_idx;
  logic [IW+TARGET_W-1:0] pick_ext;

  assign out_free  = !out_valid_r || !out_stall;
  assign pop_stall = pop_tag.last && !out_free;
  assign pop       = pop_valid && !pop_stall;

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_target_index = target_r;

  always_comb begin
    same_found_nxt = same_found_r;
    same_idx_nxt   = same_idx_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    lru_found_nxt  = lru_found_r;
    lru_idx_nxt    = lru_idx_r;
    oldest_boot_nxt = oldest_boot_r;
    pin_cnt_nxt    = pin_cnt_r;
    out_valid_nxt  = out_valid_r && out_stall;
    status_nxt     = status_r;
    target_nxt     = target_r;
    pick_idx       = '0;
    pick_ext       = '0;

    if (pop && pop_tag.use_slot) begin
      case (pop_tag.cls)
        CLS_SAME: begin
          if (!same_found_r) begin
            same_found_nxt = 1'b1;
            same_idx_nxt   = pop_idx;
          end
        end
        CLS_FREE: begin
          if (!free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = pop_idx;
          end
        end
        CLS_PIN: begin
          pin_cnt_nxt = pin_cnt_r + CW'(1);
        end
        CLS_LRU: begin
          if (!lru_found_r || (pop_boot < oldest_boot_r)) begin
            lru_found_nxt = 1'b1;
            lru_idx_nxt   = pop_idx;
            oldest_boot_nxt = pop_boot;
          end
        end
        default: ;
      endcase
    end

    if (pop && pop_tag.last) begin
      out_valid_nxt = 1'b1;
      if (same_found_nxt) begin
        pick_idx = same_idx_nxt;
      end else if (free_found_nxt) begin
        pick_idx = free_idx_nxt;
      end else begin
        pick_idx = lru_idx_nxt;
      end
      pick_ext   = {{TARGET_W{1'b0}}, pick_idx};
      target_nxt = '0;
      if (pop_count < CW'(3)) begin
        status_nxt = STATUS_SMALL;
      end else if (req_pinned &&
                   (({1'b0, pin_cnt_nxt} + (CW+1)'(3)) > {1'b0, pop_count})) begin
        status_nxt = STATUS_PIN;
      end else if (same_found_nxt || free_found_nxt || lru_found_nxt) begin
        status_nxt = STATUS_OK;
        target_nxt = pick_ext[TARGET_W-1:0];
      end else begin
        status_nxt = STATUS_FULL;
      end
      same_found_nxt = 1'b0;
      same_idx_nxt   = '0;
      free_found_nxt = 1'b0;
      free_idx_nxt   = '0;
      lru_found_nxt  = 1'b0;
      lru_idx_nxt    = '0;
      oldest_boot_nxt = '0;
      pin_cnt_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      same_found_r <= 1'b0;
      same_idx_r   <= '0;
      free_found_r <= 1'b0;
      free_idx_r   <= '0;
      lru_found_r  <= 1'b0;
      lru_idx_r    <= '0;
      oldest_boot_r <= '0;
      pin_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      same_found_r <= same_found_nxt;
      same_idx_r   <= same_idx_nxt;
      free_found_r <= free_found_nxt;
      free_idx_r   <= free_idx_nxt;
      lru_found_r  <= lru_found_nxt;
      lru_idx_r    <= lru_idx_nxt;
      oldest_boot_r <= oldest_boot_nxt;
      pin_cnt_r    <= pin_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    target_r <= target_nxt;
  end

endmodule

// ===== rtl/resume_cache_victim_select.sv =====
// Victim selection for a session-resumption cache. Stream one word per
// stored slot in slot order and flag the last; one word is taken per
// clock while in_stall is low. Each slot is classified on entry against
// the configuration registers and parked in a two-entry queue; the back
// end folds it into the running choice (matching entry, then first
// non-live slot, then oldest unpinned live slot, pinned slots counted)
// and posts status and target in an output register. Slots past
// MAX_SLOTS are ignored. Write the configuration only while no scan is open.
module resume_cache_victim_select #(
  parameter int unsigned MAX_SLOTS = rcvs_pkg::MAX_SLOTS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [rcvs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [rcvs_pkg::CFG_DAT_W-1:0]        cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_stored_valid,
  input  logic [rcvs_pkg::PURPOSE_W-1:0]        in_stored_purpose,
  input  logic [rcvs_pkg::ID_W-1:0]             in_stored_peer,
  input  logic [rcvs_pkg::ID_W-1:0]             in_stored_network,
  input  logic [rcvs_pkg::EPOCH_W-1:0]          in_stored_created_epoch,
  input  logic                                  in_stored_pinned,
  input  logic [rcvs_pkg::BOOT_W-1:0]           in_stored_last_boot,
  input  logic                                  in_stored_revoked,
  input  logic                                  in_last,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [rcvs_pkg::STATUS_W-1:0]         out_status,
  output logic [rcvs_pkg::TARGET_W-1:0]         out_target_index
);
  import rcvs_pkg::*;

  localparam int unsigned IW = $clog2(MAX_SLOTS);
  localparam int unsigned CW = $clog2(MAX_SLOTS + 1);
  localparam int unsigned TW = $bits(tag_t);
  localparam int unsigned QW = TW + IW + CW + BOOT_W;

  logic          push_valid, push_stall;
  tag_t          push_tag, pop_tag;
  logic [IW-1:0] push_idx, pop_idx;
  logic [CW-1:0] push_count, pop_count;
  logic [BOOT_W-1:0] push_boot, pop_boot;
  logic          pop_valid, pop_stall;
  logic          req_pinned;
  logic [QW-1:0] push_data, pop_data;

  rcvs_front #(.MAX_SLOTS(MAX_SLOTS)) u_front (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg_we                  (cfg_we),
    .cfg_index               (cfg_index),
    .cfg_wdata               (cfg_wdata),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_stored_valid         (in_stored_valid),
    .in_stored_purpose       (in_stored_purpose),
    .in_stored_peer          (in_stored_peer),
    .in_stored_network       (in_stored_network),
    .in_stored_created_epoch (in_stored_created_epoch),
    .in_stored_pinned        (in_stored_pinned),
    .in_stored_last_boot     (in_stored_last_boot),
    .in_stored_revoked       (in_stored_revoked),
    .in_last                 (in_last),
    .push_valid              (push_valid),
    .push_stall              (push_stall),
    .push_tag                (push_tag),
    .push_idx                (push_idx),
    .push_count              (push_count),
    .push_boot               (push_boot),
    .req_pinned              (req_pinned)
  );

  assign push_data = {push_tag, push_idx, push_count, push_boot};
  assign {pop_tag, pop_idx, pop_count, pop_boot} = pop_data;

  rcvs_queue #(.W(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_stall (push_stall),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_stall  (pop_stall),
    .pop_data   (pop_data)
  );

  rcvs_back #(.MAX_SLOTS(MAX_SLOTS)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .pop_valid        (pop_valid),
    .pop_stall        (pop_stall),
    .pop_tag          (pop_tag),
    .pop_idx          (pop_idx),
    .pop_count        (pop_count),
    .pop_boot         (pop_boot),
    .req_pinned       (req_pinned),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_target_index (out_target_index)
  );

endmodule
